FILE: src/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
// Used by skf_alu, skf_seq and scalar_kalman_filter; depends on nothing.
package skf_pkg;

  // Data format: signed/unsigned Q16.16
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  // Gain is 0 to 1.0 inclusive, one integer bit plus the fraction
  localparam int GAIN_W  = FRAC_W + 1;
  // Working width of the shared unit: covers doubled remainders and signed sums
  localparam int ALU_W   = DATA_W + 3;
  // Restoring divider: one integer step plus one per fraction bit
  localparam int DIV_STEPS = FRAC_W + 1;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] ONE_G = GAIN_W'(1) << FRAC_W;

  // Register reset values: 0.03 and 10.0
  localparam logic [DATA_W-1:0] Q_RESET = DATA_W'((3 << FRAC_W) / 100);
  localparam logic [DATA_W-1:0] R_RESET = DATA_W'(10 << FRAC_W);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 1'b1;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  // Sequencer status toward the stream side
  typedef struct packed {
    logic idle;
    logic res_valid;
  } skf_status_t;

endpackage

FILE: src/skf_alu.sv
// Shared arithmetic unit of the scalar Kalman filter: add, subtract, fraction multiply.
// Depends on skf_pkg.
module skf_alu (
  input  skf_pkg::alu_op_e               op_i,
  input  logic [skf_pkg::ALU_W-1:0]      a_i,
  input  logic [skf_pkg::ALU_W-1:0]      b_i,
  output logic [skf_pkg::ALU_W-1:0]      res_o
);

  localparam int PROD_W = skf_pkg::DATA_W + 2 + skf_pkg::GAIN_W;

  logic [PROD_W-1:0] prod;

  // Magnitude times gain; the low fraction bits are dropped (truncate)
  assign prod = PROD_W'(a_i[skf_pkg::DATA_W+1:0]) * PROD_W'(b_i[skf_pkg::GAIN_W-1:0]);

  // Select the operation
  always_comb begin
    case (op_i)
      skf_pkg::ALU_ADD: res_o = a_i + b_i;
      skf_pkg::ALU_SUB: res_o = a_i - b_i;
      skf_pkg::ALU_MUL: res_o = prod[skf_pkg::FRAC_W +: skf_pkg::ALU_W];
      default:          res_o = '0;
    endcase
  end

endmodule

FILE: src/skf_seq.sv
// Sequencer and state of the scalar Kalman filter; runs every step through skf_alu.
// Depends on skf_pkg and skf_alu.
module skf_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [skf_pkg::DATA_W-1:0]    meas_i,
  input  logic [skf_pkg::DATA_W-1:0]    q_i,
  input  logic [skf_pkg::DATA_W-1:0]    r_i,
  input  logic                          res_take_i,
  output skf_pkg::skf_status_t          status_o,
  output logic [skf_pkg::DATA_W-1:0]    estimate_o
);

  localparam int DW = skf_pkg::DATA_W;
  localparam int AW = skf_pkg::ALU_W;
  localparam int GW = skf_pkg::GAIN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PSUM,
    S_DSUM,
    S_DIFF,
    S_ABS,
    S_DIV,
    S_GINV,
    S_MULX,
    S_UPDX,
    S_MULP,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [skf_pkg::CNT_W-1:0] cnt_q;
  logic [DW-1:0]            z_q, x_q, p_q, pmid_q, xnew_q, pnew_q;
  logic [DW:0]              den_q;
  logic [DW+1:0]            rem_q;
  logic [DW+1:0]            diff_q;
  logic [DW:0]              mag_q, delta_q;
  logic                     neg_q;
  logic [GW-1:0]            g_q, gi_q;

  skf_pkg::alu_op_e         alu_op;
  logic [AW-1:0]            alu_a, alu_b, alu_res;
  logic                     res_neg;
  logic [AW-DW:0]           x_top;

  skf_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign res_neg = alu_res[AW-1];
  assign x_top   = alu_res[AW-1:DW-1];

  // Route operands to the shared unit for the current step
  always_comb begin
    alu_op = skf_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      S_PSUM: begin
        alu_a = AW'(p_q);
        alu_b = AW'(q_i);
      end
      S_DSUM: begin
        alu_a = AW'(pmid_q);
        alu_b = AW'(r_i);
      end
      S_DIFF: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = {{(AW-DW){z_q[DW-1]}}, z_q};
        alu_b  = {{(AW-DW){x_q[DW-1]}}, x_q};
      end
      S_ABS: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = {diff_q[DW+1], diff_q};
      end
      S_DIV: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = (cnt_q == '0) ? AW'(rem_q) : {rem_q, 1'b0};
        alu_b  = AW'(den_q);
      end
      S_GINV: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = AW'(skf_pkg::ONE_G);
        alu_b  = AW'(g_q);
      end
      S_MULX: begin
        alu_op = skf_pkg::ALU_MUL;
        alu_a  = AW'(mag_q);
        alu_b  = AW'(g_q);
      end
      S_UPDX: begin
        alu_op = neg_q ? skf_pkg::ALU_SUB : skf_pkg::ALU_ADD;
        alu_a  = {{(AW-DW){x_q[DW-1]}}, x_q};
        alu_b  = AW'(delta_q);
      end
      S_MULP: begin
        alu_op = skf_pkg::ALU_MUL;
        alu_a  = AW'(pmid_q);
        alu_b  = AW'(gi_q);
      end
      default: begin
        alu_op = skf_pkg::ALU_ADD;
      end
    endcase
  end

  // Advance the sequencer and capture each step's result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      x_q     <= '0;
      p_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            z_q     <= meas_i;
            state_q <= S_PSUM;
          end
        end
        S_PSUM: begin
          // Saturate the grown covariance
          pmid_q  <= (alu_res[AW-1:DW] != '0) ? '1 : alu_res[DW-1:0];
          state_q <= S_DSUM;
        end
        S_DSUM: begin
          den_q   <= alu_res[DW:0];
          rem_q   <= (DW+2)'(pmid_q);
          g_q     <= '0;
          cnt_q   <= '0;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          diff_q  <= alu_res[DW+1:0];
          neg_q   <= res_neg;
          state_q <= S_ABS;
        end
        S_ABS: begin
          mag_q   <= neg_q ? alu_res[DW:0] : diff_q[DW:0];
          // Zero denominator: keep the gain at zero
          state_q <= (den_q == '0) ? S_GINV : S_DIV;
        end
        S_DIV: begin
          // Restoring step: keep the difference when it does not go negative
          if (!res_neg) begin
            rem_q <= alu_res[DW+1:0];
            g_q   <= {g_q[GW-2:0], 1'b1};
          end else begin
            rem_q <= alu_a[DW+1:0];
            g_q   <= {g_q[GW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
            state_q <= S_GINV;
          end
        end
        S_GINV: begin
          gi_q    <= alu_res[GW-1:0];
          state_q <= S_MULX;
        end
        S_MULX: begin
          delta_q <= alu_res[DW:0];
          state_q <= S_UPDX;
        end
        S_UPDX: begin
          // Clamp to the signed range
          if (x_top != '0 && x_top != '1) begin
            xnew_q <= res_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
          end else begin
            xnew_q <= alu_res[DW-1:0];
          end
          state_q <= S_MULP;
        end
        S_MULP: begin
          pnew_q  <= (alu_res[AW-1:DW] != '0) ? '1 : alu_res[DW-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register takes it
          if (res_take_i) begin
            x_q     <= xnew_q;
            p_q     <= pnew_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign status_o.idle      = (state_q == S_IDLE);
  assign status_o.res_valid = (state_q == S_DONE);
  assign estimate_o         = xnew_q;

  // The output side only takes a result that is on offer
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take_i |-> status_o.res_valid)
    else $error("result taken while none is ready");

  // The gain never exceeds one
  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GINV) |-> (g_q <= skf_pkg::ONE_G))
    else $error("gain above one");

  // The updated covariance never exceeds the predicted one
  a_cov_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (pnew_q <= pmid_q))
    else $error("covariance grew in the update");

  // A taken result returns the sequencer to idle with the new estimate stored
  a_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take_i |=> (state_q == S_IDLE) && (x_q == $past(xnew_q)))
    else $error("estimate not written back");

endmodule

FILE: src/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: stream ports, noise registers, output register.
// Depends on skf_pkg and skf_seq.
//
// Channel   Direction  Handshake          Payload
// s_axis    in         tvalid / tready    tdata[31:0] = measurement
// m_axis    out        tvalid / tready    tdata[31:0] = estimate
// cfg       in         cfg_we_i           cfg_idx_i selects register, cfg_data_i value
//
// Each measurement runs through the sequencer steps in order, with the restoring
// gain division on the shared adder; no new measurement is taken before idle.
// A zero gain denominator skips the division.
// Reset clears estimate and covariance and loads Q = 0.03 and R = 10.0.
// The next measurement is taken while the previous estimate waits in the output
// register; a stalled output holds the sequencer at its last step.
module scalar_kalman_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [skf_pkg::DATA_W-1:0]        s_axis_tdata,   // [31:0] measurement
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [skf_pkg::DATA_W-1:0]        m_axis_tdata,   // [31:0] estimate
  input  logic                              cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [skf_pkg::DATA_W-1:0]        cfg_data_i
);

  logic [skf_pkg::DATA_W-1:0] q_noise_q, r_noise_q;
  logic [skf_pkg::DATA_W-1:0] out_data_q, estimate;
  logic                       out_valid_q;
  logic                       res_take;
  skf_pkg::skf_status_t       status;

  // Noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= skf_pkg::Q_RESET;
      r_noise_q <= skf_pkg::R_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        skf_pkg::CFG_PROCESS_NOISE: q_noise_q <= cfg_data_i;
        skf_pkg::CFG_MEASURE_NOISE: r_noise_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  skf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && s_axis_tready),
    .meas_i     (s_axis_tdata),
    .q_i        (q_noise_q),
    .r_i        (r_noise_q),
    .res_take_i (res_take),
    .status_o   (status),
    .estimate_o (estimate)
  );

  assign s_axis_tready = status.idle;

  // Load the output register when it is empty or being drained
  assign res_take = status.res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= estimate;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: tb/scalar_kalman_filter_tb.sv
// Self-checking testbench for the scalar Kalman filter (scalar_kalman_filter).
// Predicts every estimate with its own fixed-point filter and checks the stream output.
// Depends on skf_pkg and the filter RTL.
`timescale 1ns / 100ps

module scalar_kalman_filter_tb;

  localparam int          DATA_W      = skf_pkg::DATA_W;
  localparam int          FRAC_W      = skf_pkg::FRAC_W;
  localparam int          CFG_IDX_W   = skf_pkg::CFG_IDX_W;
  localparam int          CLK_PERIOD  = 10;
  localparam int          CYCLE_LIMIT = 600_000;
  localparam int          RAND_ITEMS  = 400;
  localparam int          PHASE_ITEMS = 50;
  localparam logic [63:0] DATA_MAX    = (64'd1 << DATA_W) - 1;
  localparam longint      EST_MAX     = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint      EST_MIN     = -EST_MAX - 1;
  localparam logic [63:0] GAIN_ONE    = 64'd1 << FRAC_W;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;   // [31:0] measurement
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;   // [31:0] estimate
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;

  // Filter state and noise registers as the predictor sees them
  longint            flt_est   = 0;
  logic [63:0]       flt_cov   = '0;
  logic [63:0]       noise_q   = 64'(skf_pkg::Q_RESET);
  logic [63:0]       noise_r   = 64'(skf_pkg::R_RESET);

  logic [DATA_W-1:0] pending_estimates[$];
  int                fail_cnt       = 0;
  int                sample_cnt     = 0;
  int                estimate_cnt   = 0;
  int                setting_cnt    = 0;
  int                cycle_cnt      = 0;
  int                sink_stall     = 0;
  bit                gaps_on        = 1'b1;

  scalar_kalman_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // floor(mag * g / 2^FRAC_W), split so no intermediate overflows
  function automatic logic [63:0] scale_by_gain(logic [63:0] mag, logic [63:0] g);
    return (mag >> FRAC_W) * g + (((mag & (GAIN_ONE - 1)) * g) >> FRAC_W);
  endfunction

  // Advance the filter by one measurement and return the new estimate
  function automatic logic [DATA_W-1:0] next_estimate(logic [DATA_W-1:0] z_bits);
    logic [63:0] p_mid;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] gain;
    logic [63:0] mag;
    logic [63:0] p_new;
    longint      z;
    longint      diff;
    longint      x_new;
    z     = longint'($signed(z_bits));
    p_mid = flt_cov + noise_q;
    if (p_mid > DATA_MAX) p_mid = DATA_MAX;
    den  = p_mid + noise_r;
    gain = '0;
    // Restoring division: one integer step, then one per fraction bit
    if (den != 0) begin
      rem = p_mid;
      if (rem >= den) begin
        rem  = rem - den;
        gain = 64'd1;
      end
      for (int i = 0; i < FRAC_W; i++) begin
        rem  = rem << 1;
        gain = gain << 1;
        if (rem >= den) begin
          rem  = rem - den;
          gain = gain | 64'd1;
        end
      end
    end
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    // Move toward the measurement, truncating the step toward zero
    diff  = z - flt_est;
    mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
    x_new = (diff < 0) ? flt_est - longint'(scale_by_gain(mag, gain))
                       : flt_est + longint'(scale_by_gain(mag, gain));
    if (x_new > EST_MAX) x_new = EST_MAX;
    if (x_new < EST_MIN) x_new = EST_MIN;
    p_new = scale_by_gain(p_mid, GAIN_ONE - gain);
    if (p_new > DATA_MAX) p_new = DATA_MAX;
    flt_est = x_new;
    flt_cov = p_new;
    return x_new[DATA_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Track accepted beats: predict on input, check on output
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] exp_est;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          skf_pkg::CFG_PROCESS_NOISE: noise_q = 64'(cfg_data_i);
          skf_pkg::CFG_MEASURE_NOISE: noise_r = 64'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_estimates.push_back(next_estimate(s_axis_tdata));
        sample_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        estimate_cnt++;
        if (pending_estimates.size() == 0) begin
          $display("%t unexpected estimate beat: actual %h", $realtime, m_axis_tdata);
          fail_cnt++;
        end else begin
          exp_est = pending_estimates.pop_front();
          if (m_axis_tdata !== exp_est) begin
            $display("%t estimate mismatch: expected %h, actual %h",
                     $realtime, exp_est, m_axis_tdata);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Stall the output side at random
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= sink_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall    <= pick_gap();
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d estimates outstanding",
               cycle_cnt, pending_estimates.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one measurement beat; called and returns at a falling edge
  task automatic send_measurement(logic [DATA_W-1:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= z;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every estimate has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk_i);
  endtask

  // Load both noise registers while the filter is idle
  task automatic set_noise(logic [DATA_W-1:0] q, logic [DATA_W-1:0] r);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= skf_pkg::CFG_PROCESS_NOISE;
    cfg_data_i <= q;
    @(negedge clk_i);
    cfg_idx_i  <= skf_pkg::CFG_MEASURE_NOISE;
    cfg_data_i <= r;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    setting_cnt++;
  endtask

  function automatic logic [DATA_W-1:0] pick_noise(logic [DATA_W-1:0] dflt);
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      3:       return DATA_W'($urandom_range(0, 1 << 20));
      4:       return DATA_W'($urandom) >> $urandom_range(0, DATA_W - 1);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_measurement();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return DATA_W'($urandom);
    if (roll < 75) return DATA_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    if (roll < 90) return DATA_W'(flt_est + $signed($urandom_range(0, 2000)) - 1000);
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(DATA_W - 1){1'b1}}};
      1:       return {1'b1, {(DATA_W - 1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Reset noise values, extreme measurements
  task automatic test_reset_defaults();
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement('0);
    send_measurement('1);
  endtask

  // R = 0: gain is one, estimate jumps to the measurement, covariance clears
  task automatic test_unit_gain();
    set_noise(DATA_W'(1 << FRAC_W), '0);
    send_measurement(DATA_W'(32'h0001_8000));
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
  endtask

  // Q = R = 0 with covariance already zero: gain forced to zero
  task automatic test_zero_denominator();
    set_noise('0, '0);
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement(DATA_W'(32'h1234_5678));
  endtask

  // Full-scale Q drives the covariance sum into saturation
  task automatic test_covariance_saturation();
    set_noise('1, '1);
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement('0);
    set_noise('1, '0);
    send_measurement(DATA_W'(32'hDEAD_BEEF));
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
  endtask

  // Tiny and half gains with full-swing steps
  task automatic test_gain_extremes();
    set_noise(DATA_W'(1), '1);
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
    send_measurement(DATA_W'(32'hAAAA_5555));
    set_noise(DATA_W'(1 << FRAC_W), DATA_W'(1 << FRAC_W));
    send_measurement({1'b0, {(DATA_W - 1){1'b1}}});
    send_measurement({1'b1, {(DATA_W - 1){1'b0}}});
    send_measurement(DATA_W'(32'h5555_AAAA));
  endtask

  // Random measurements in phases, each with its own noise setting
  task automatic test_random_stream(int n_items);
    int phase;
    phase = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        set_noise(pick_noise(skf_pkg::Q_RESET), pick_noise(skf_pkg::R_RESET));
        // one phase runs back to back with no gaps at all
        gaps_on = (phase != 2);
        phase++;
      end
      if ($urandom_range(0, 24) == 0) drain();
      send_measurement(pick_measurement());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = skf_pkg::CFG_PROCESS_NOISE;
    cfg_data_i    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_unit_gain();
    test_zero_denominator();
    test_covariance_saturation();
    test_gain_extremes();
    test_random_stream(RAND_ITEMS);

    drain();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d measurements (%0d estimates checked) over %0d noise settings,",
             sample_cnt, estimate_cnt, setting_cnt);
    $display("including unit gain, zero gain, saturated covariance and stalled streams.");
    if (fail_cnt == 0 && pending_estimates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
